// ----- rtl/core/msqw_pkg.sv -----
// shared types and constants for the multi-server queue wait block
`default_nettype none
package msqw_pkg;

	localparam int SERVER_COUNT = 16;
	localparam int IDX_W = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;
	localparam int CNT_W = $clog2(SERVER_COUNT + 1);

	localparam int TIME_W = 32;
	localparam int FINISH_W = 33;
	localparam int SUM_W = 63;
	localparam int NS_W = 5;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic ADDR_NUM_SERVERS = 1'b0;

	localparam logic [FINISH_W-1:0] FINISH_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [TIME_W-1:0] WAIT_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] service_time;
		logic first_of_run;
	} msqw_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] wait_time;
		logic [SUM_W-1:0] total_wait;
	} msqw_rsp_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] addr;
		logic [FINISH_W-1:0] data;
	} msqw_wr_t;

endpackage
`default_nettype wire

// ----- rtl/core/multi_server_queue_wait.sv -----
// multi-server fifo queue: earliest-finish server pick, wait and total wait
// req to rsp: a scan over the n = servers in use, then update, which sets rsp valid
// when the output slot is free; requests are taken only in idle, paced by the
//   one-entry-per-cycle scan of the finish time memory through its single read port
// reset: finish times and total wait clear to zero, num_servers to 1; no clearing pass
`default_nettype none
module multi_server_queue_wait
	import msqw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire msqw_req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output msqw_rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic [NS_W-1:0] num_servers_q;
	logic [TIME_W-1:0] arrival_q;
	logic [TIME_W-1:0] service_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pick_q;
	logic [FINISH_W-1:0] best_q;
	logic [SUM_W-1:0] wait_sum_q;

	logic req_fire;
	logic clear_run;
	logic [CNT_W-1:0] n_use;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W:0] idx_next;
	logic [FINISH_W-1:0] rd_data;
	logic last_entry;
	logic slot_free;
	logic late;
	logic [FINISH_W-1:0] wait_full;
	logic [FINISH_W-1:0] start_time;
	logic [FINISH_W:0] fin_sum;
	logic [FINISH_W-1:0] fin_time;
	logic [SUM_W:0] sum_full;
	logic [SUM_W-1:0] sum_next;
	logic [TIME_W-1:0] wait_sat;
	msqw_wr_t wr;

	// configuration
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_servers_q <= NS_W'(1);
		end else if (psel && penable && pwrite && paddr[2] == ADDR_NUM_SERVERS) begin
			num_servers_q <= pwdata[NS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == ADDR_NUM_SERVERS) begin
			prdata = PDATA_W'(num_servers_q);
		end
	end

	// zero servers means one, too many means all built
	always_comb begin
		if (num_servers_q == '0) begin
			n_use = CNT_W'(1);
		end else if (32'(num_servers_q) > SERVER_COUNT) begin
			n_use = CNT_W'(SERVER_COUNT);
		end else begin
			n_use = CNT_W'(num_servers_q);
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire = req_valid && req_ready;
	assign clear_run = req_fire && req.first_of_run;

	// read one entry ahead of the one being compared
	assign idx_next = {1'b0, idx_q} + (IDX_W+1)'(1);
	always_comb begin
		if (state_q == ST_IDLE || 32'(idx_next) >= SERVER_COUNT) begin
			rd_addr = '0;
		end else begin
			rd_addr = idx_next[IDX_W-1:0];
		end
	end

	assign last_entry = (CNT_W'(idx_q) == n_q - CNT_W'(1));
	assign slot_free = !rsp_valid || rsp_ready;

	// update arithmetic
	assign late = best_q > {1'b0, arrival_q};
	assign wait_full = late ? (best_q - {1'b0, arrival_q}) : '0;
	assign start_time = late ? best_q : {1'b0, arrival_q};
	assign fin_sum = {1'b0, start_time} + (FINISH_W+1)'(service_q);
	assign fin_time = fin_sum[FINISH_W] ? FINISH_MAX : fin_sum[FINISH_W-1:0];
	assign sum_full = {1'b0, wait_sum_q} + (SUM_W+1)'(wait_full);
	assign sum_next = sum_full[SUM_W] ? SUM_MAX : sum_full[SUM_W-1:0];
	assign wait_sat = wait_full[FINISH_W-1] ? WAIT_MAX : wait_full[TIME_W-1:0];

	always_comb begin
		wr.en = (state_q == ST_UPDATE) && slot_free;
		wr.addr = pick_q;
		wr.data = fin_time;
	end

	msqw_ftime_mem u_ftime_mem (
		.clk(clk),
		.arst_n(arst_n),
		.clear(clear_run),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr(wr)
	);

	always_ff @(posedge clk) begin
		if (req_fire) begin
			arrival_q <= req.arrival_time;
			service_q <= req.service_time;
			n_q <= n_use;
		end
		if (state_q == ST_SCAN && (idx_q == '0 || rd_data < best_q)) begin
			best_q <= rd_data;
			pick_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			wait_sum_q <= '0;
			rsp_valid <= 1'b0;
			rsp <= '0;
		end else begin
			// in update a free slot loads the next transaction instead
			if (rsp_valid && rsp_ready && state_q != ST_UPDATE) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						idx_q <= '0;
						if (req.first_of_run) begin
							wait_sum_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_entry) begin
						state_q <= ST_UPDATE;
					end else begin
						idx_q <= idx_next[IDX_W-1:0];
					end
				end
				ST_UPDATE: begin
					// hold here while the previous transaction is still waiting
					if (slot_free) begin
						wait_sum_q <= sum_next;
						rsp.wait_time <= wait_sat;
						rsp.total_wait <= sum_next;
						rsp_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/msqw_ftime_mem.sv -----
// finish time store: synchronous memory with per-entry valid bits
`default_nettype none
module msqw_ftime_mem
	import msqw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic clear,
	input wire logic [IDX_W-1:0] rd_addr,
	output logic [FINISH_W-1:0] rd_data,
	input wire msqw_wr_t wr
);

	logic [FINISH_W-1:0] mem [SERVER_COUNT];
	logic [SERVER_COUNT-1:0] valid_q;
	logic [FINISH_W-1:0] rd_data_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			// a read issued while clearing sees the cleared entry
			rd_valid_q <= valid_q[rd_addr] & ~clear;
		end
	end

	// entries never written since the last clear read as zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire
